### rtl/gmdd_pkg.sv
// shared types, constants and register codes for the glyph mask downsample/dilate core
// no dependencies; used by every rtl file of the block
`default_nettype none
package gmdd_pkg;

   // default sizing of the mask grid and dilation window
   localparam int DEF_MAX_CELL_WIDTH  = 32;
   localparam int DEF_MAX_CELL_HEIGHT = 32;
   localparam int DEF_MAX_BOLD_RADIUS = 3;

   // field widths, sized for the largest grid the parameters allow (64 cells)
   localparam int SIZE_W     = 7;   // effective width/height, 1..64
   localparam int COORD_W    = 6;   // cell column/row, 0..63
   localparam int RAD_W      = 4;   // effective radius, 0..3
   localparam int RASTER_W   = 8;   // pixel column/row, 0..127
   localparam int COLOR_W    = 8;
   localparam int GRAY_W     = 8;
   localparam int SUM_W      = 10;
   localparam int LEVEL_W    = 4;
   localparam int CELL_IN_W  = 5;   // cell_x / cell_y on the request

   // stream and register port widths
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;
   localparam int CFG_SIZE_W  = 6;
   localparam int CFG_RAD_W   = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CELL_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CELL_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BOLD_RADIUS = 2'd2;

   // register reset values
   localparam logic [CFG_SIZE_W-1:0] RESET_CELL_WIDTH  = 6'd11;
   localparam logic [CFG_SIZE_W-1:0] RESET_CELL_HEIGHT = 6'd14;
   localparam logic [CFG_RAD_W-1:0]  RESET_BOLD_RADIUS = 2'd0;

   // request kinds
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // arithmetic constants
   localparam int GRAY_PROD_W = 20;
   localparam logic [GRAY_PROD_W-1:0] GRAY_RECIP = 20'd683;  // 2048/3 rounded up
   localparam int GRAY_SHIFT  = 11;
   localparam int LVL_W       = 12;
   localparam logic [LVL_W-1:0] LEVEL_ROUND = 12'd127;
   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 4'd9;
   localparam logic [LEVEL_W-1:0] ZERO_LEVEL = 4'd0;

   localparam int QUEUE_DEPTH = 2;

   // effective configuration seen by front and back
   typedef struct packed {
      logic [SIZE_W-1:0] eff_w;
      logic [SIZE_W-1:0] eff_h;
      logic [RAD_W-1:0]  rad;
   } cfg_type;

   // classified command handed from front to back
   typedef struct packed {
      logic               is_read;
      logic               overwrite;  // top-left pixel of a 2x2 block
      logic               finish;     // bottom-right pixel of a 2x2 block
      logic [GRAY_W-1:0]  gray;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } cmd_type;

endpackage
`default_nettype wire

### rtl/gmdd_queue.sv
// two-entry command queue between the front and back parts
// depends on gmdd_pkg for the command type
`default_nettype none
module gmdd_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  gmdd_pkg::cmd_type   push_cmd,
   input  wire                 pop,
   output gmdd_pkg::cmd_type   pop_cmd,
   output logic                full,
   output logic                not_empty
);

   localparam int PTR_W = (gmdd_pkg::QUEUE_DEPTH > 1) ? $clog2(gmdd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(gmdd_pkg::QUEUE_DEPTH + 1);

   gmdd_pkg::cmd_type slot_ff [gmdd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(gmdd_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full      = (count_ff == CNT_W'(gmdd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

### rtl/gmdd_front.sv
// front part: accepts request transfers, tracks the raster position and forms gray
// depends on gmdd_pkg for the command and configuration types
`default_nettype none
module gmdd_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  gmdd_pkg::cfg_type                    cfg,
   input  wire                                  restart,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [gmdd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire  [gmdd_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  wire                                  q_full,
   output logic                                 q_push,
   output gmdd_pkg::cmd_type                    q_cmd
);

   logic [gmdd_pkg::RASTER_W-1:0] col_ff, col_in;
   logic [gmdd_pkg::RASTER_W-1:0] row_ff, row_in;

   logic                               func;
   logic                               first_pixel;
   logic [gmdd_pkg::COLOR_W-1:0]       blue, green, red;
   logic [gmdd_pkg::CELL_IN_W-1:0]     cell_x, cell_y;
   logic [gmdd_pkg::SUM_W-1:0]         rgb_sum;
   logic [gmdd_pkg::GRAY_PROD_W-1:0]   gray_prod;
   logic [gmdd_pkg::RASTER_W-1:0]      span_w, span_h;
   logic [gmdd_pkg::RASTER_W-1:0]      start_col, start_row;
   logic [gmdd_pkg::RASTER_W-1:0]      pos_col, pos_row;
   logic [gmdd_pkg::RASTER_W-1:0]      next_col, next_row;

   assign func        = req_tuser[0];
   assign first_pixel = req_tuser[1];
   assign blue        = req_tdata[7:0];
   assign green       = req_tdata[15:8];
   assign red         = req_tdata[23:16];
   assign cell_x      = req_tdata[28:24];
   assign cell_y      = req_tdata[33:29];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // floor(sum/3) by reciprocal, exact for sums below 2048
   assign rgb_sum   = gmdd_pkg::SUM_W'(blue) + gmdd_pkg::SUM_W'(green)
                      + gmdd_pkg::SUM_W'(red);
   assign gray_prod = gmdd_pkg::GRAY_PROD_W'(rgb_sum) * gmdd_pkg::GRAY_RECIP;

   always_comb begin
      span_w    = {cfg.eff_w, 1'b0};
      span_h    = {cfg.eff_h, 1'b0};
      start_col = first_pixel ? '0 : col_ff;
      start_row = first_pixel ? '0 : row_ff;
      // out of the grid (size shrank) restarts at the top
      if (start_col >= span_w || start_row >= span_h) begin
         pos_col = '0;
         pos_row = '0;
      end else begin
         pos_col = start_col;
         pos_row = start_row;
      end
      next_col = pos_col + 1'b1;
      next_row = pos_row;
      if (next_col >= span_w) begin
         next_col = '0;
         next_row = pos_row + 1'b1;
         if (next_row >= span_h) begin
            next_row = '0;
         end
      end

      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (q_push && func == gmdd_pkg::FUNC_PUSH) begin
         col_in = next_col;
         row_in = next_row;
      end

      q_cmd.is_read = (func == gmdd_pkg::FUNC_READ);
      if (func == gmdd_pkg::FUNC_READ) begin
         q_cmd.overwrite = 1'b0;
         q_cmd.finish    = 1'b0;
         q_cmd.gray      = '0;
         q_cmd.x         = gmdd_pkg::COORD_W'(cell_x);
         q_cmd.y         = gmdd_pkg::COORD_W'(cell_y);
      end else begin
         q_cmd.overwrite = !pos_col[0] && !pos_row[0];
         q_cmd.finish    = pos_col[0] && pos_row[0];
         q_cmd.gray      = gmdd_pkg::GRAY_W'(gray_prod >> gmdd_pkg::GRAY_SHIFT);
         q_cmd.x         = pos_col[gmdd_pkg::COORD_W:1];
         q_cmd.y         = pos_row[gmdd_pkg::COORD_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule
`default_nettype wire

### rtl/gmdd_back.sv
// back part: column accumulators, level store, window scan and result register
// depends on gmdd_pkg for the command and configuration types
`default_nettype none
module gmdd_back #(
   parameter int MAX_CELL_WIDTH  = gmdd_pkg::DEF_MAX_CELL_WIDTH,
   parameter int MAX_CELL_HEIGHT = gmdd_pkg::DEF_MAX_CELL_HEIGHT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  gmdd_pkg::cfg_type                    cfg,
   input  wire                                  q_valid,
   input  gmdd_pkg::cmd_type                    q_cmd,
   output logic                                 q_pop,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [gmdd_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int XW     = (MAX_CELL_WIDTH > 1) ? $clog2(MAX_CELL_WIDTH) : 1;
   localparam int DEPTH  = MAX_CELL_WIDTH * MAX_CELL_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_PRD   = 3'd5;
   localparam logic [2:0] S_PACC  = 3'd6;
   localparam logic [2:0] S_PLVL  = 3'd7;

   logic [gmdd_pkg::SUM_W-1:0]   sums_mem  [MAX_CELL_WIDTH];
   logic [gmdd_pkg::LEVEL_W-1:0] level_mem [DEPTH];

   logic [2:0]                      state_ff, state_in;
   gmdd_pkg::cmd_type               cmd_ff;
   logic [gmdd_pkg::COORD_W-1:0]    i_ff, i_in, j_ff, j_in;
   logic [gmdd_pkg::COORD_W-1:0]    x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic                            chk_ff;
   logic [gmdd_pkg::LEVEL_W-1:0]    lvl_q_ff;
   logic                            hit_ff, hit_in;
   logic [gmdd_pkg::LEVEL_W-1:0]    val_ff, val_in;
   logic                            direct_ff, direct_in;
   logic                            zero_ff, zero_in;
   logic [gmdd_pkg::SUM_W-1:0]      sums_q_ff;
   logic [gmdd_pkg::GRAY_W-1:0]     avg_ff, avg_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [gmdd_pkg::LEVEL_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                            out_free;
   logic [gmdd_pkg::SUM_W-1:0]      new_sum;
   logic [gmdd_pkg::LVL_W-1:0]      lvl_num, lvl_div;
   logic [gmdd_pkg::LEVEL_W-1:0]    new_level;
   logic [gmdd_pkg::COORD_W-1:0]    rad6;
   logic [gmdd_pkg::SIZE_W-1:0]     hi_x, hi_y;
   logic [gmdd_pkg::COORD_W-1:0]    y0_calc;
   logic [ADDR_W-1:0]               scan_addr, cell_addr;
   logic [XW-1:0]                   col_idx;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = gmdd_pkg::RSP_TDATA_W'(rsp_data_ff);

   assign col_idx   = cmd_ff.x[XW-1:0];
   assign scan_addr = ADDR_W'(32'(j_ff) * 32'(MAX_CELL_WIDTH) + 32'(i_ff));
   assign cell_addr = ADDR_W'(32'(cmd_ff.y) * 32'(MAX_CELL_WIDTH) + 32'(cmd_ff.x));

   // accumulate, then level = floor((avg*9+127)/255) via (n + n/256 + 1)/256
   assign new_sum   = cmd_ff.overwrite ? gmdd_pkg::SUM_W'(cmd_ff.gray)
                                       : sums_q_ff + gmdd_pkg::SUM_W'(cmd_ff.gray);
   assign lvl_num   = (gmdd_pkg::LVL_W'(avg_ff) << 3) + gmdd_pkg::LVL_W'(avg_ff)
                      + gmdd_pkg::LEVEL_ROUND;
   assign lvl_div   = lvl_num + (lvl_num >> 8) + 1'b1;
   assign new_level = lvl_div[gmdd_pkg::LVL_W-1:8];

   // clipped window bounds
   assign rad6    = gmdd_pkg::COORD_W'(cfg.rad);
   assign hi_x    = gmdd_pkg::SIZE_W'(cmd_ff.x) + gmdd_pkg::SIZE_W'(cfg.rad);
   assign hi_y    = gmdd_pkg::SIZE_W'(cmd_ff.y) + gmdd_pkg::SIZE_W'(cfg.rad);
   assign y0_calc = (cmd_ff.y >= rad6) ? cmd_ff.y - rad6 : '0;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      hit_in       = hit_ff;
      val_in       = val_ff;
      direct_in    = direct_ff;
      zero_in      = zero_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // fold each level read back from the store
      if (chk_ff) begin
         hit_in = hit_ff || (lvl_q_ff != gmdd_pkg::ZERO_LEVEL);
         val_in = lvl_q_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               state_in = q_cmd.is_read ? S_SETUP : S_PRD;
            end
         end
         S_SETUP: begin
            hit_in    = 1'b0;
            direct_in = (cfg.rad == '0);
            zero_in   = (gmdd_pkg::SIZE_W'(cmd_ff.x) >= cfg.eff_w)
                        || (gmdd_pkg::SIZE_W'(cmd_ff.y) >= cfg.eff_h);
            x0_in     = (cmd_ff.x >= rad6) ? cmd_ff.x - rad6 : '0;
            x1_in     = (hi_x < cfg.eff_w) ? gmdd_pkg::COORD_W'(hi_x)
                                           : gmdd_pkg::COORD_W'(cfg.eff_w - 1'b1);
            y1_in     = (hi_y < cfg.eff_h) ? gmdd_pkg::COORD_W'(hi_y)
                                           : gmdd_pkg::COORD_W'(cfg.eff_h - 1'b1);
            i_in      = x0_in;
            j_in      = y0_calc;
            state_in  = zero_in ? S_EMIT : S_SCAN;
         end
         S_SCAN: begin
            if (i_ff == x1_ff) begin
               i_in = x0_ff;
               j_in = j_ff + 1'b1;
               if (j_ff == y1_ff) begin
                  state_in = S_DRAIN;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (zero_ff) begin
                  rsp_data_in = gmdd_pkg::ZERO_LEVEL;
               end else if (direct_ff) begin
                  rsp_data_in = val_ff;
               end else begin
                  rsp_data_in = hit_ff ? gmdd_pkg::FULL_LEVEL : gmdd_pkg::ZERO_LEVEL;
               end
               state_in = S_IDLE;
            end
         end
         S_PRD: begin
            state_in = S_PACC;
         end
         S_PACC: begin
            avg_in   = new_sum[gmdd_pkg::SUM_W-1:2];
            state_in = cmd_ff.finish ? S_PLVL : S_IDLE;
         end
         S_PLVL: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= (state_ff == S_SCAN);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      hit_ff      <= hit_in;
      val_ff      <= val_in;
      direct_ff   <= direct_in;
      zero_ff     <= zero_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // column accumulators: one read, one write port
   always_ff @(posedge clock) begin
      if (state_ff == S_PRD) begin
         sums_q_ff <= sums_mem[col_idx];
      end
      if (state_ff == S_PACC) begin
         sums_mem[col_idx] <= new_sum;
      end
   end

   // level store: one write, one registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_PLVL) begin
         level_mem[cell_addr] <= new_level;
      end
      if (state_ff == S_SCAN) begin
         lvl_q_ff <= level_mem[scan_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/glyph_mask_downsample_dilate_core.sv
// top level: config registers, front, command queue and back (needs gmdd_pkg and those modules)
// order: a pixel passes the queue and the back's idle, read and accumulate states; the last
//   pixel of a 2x2 block also writes its level; a read goes idle, setup, scan, drain, emit
//   (off the grid, setup goes straight to emit); the back finishes each command before it pops
//   the next, and a scan reads the level store's single read port one cell per cycle
// reset: synchronous, active high; clears raster, queue, fsm and result valid, not the stores
`default_nettype none
module glyph_mask_downsample_dilate_core #(
   parameter int MAX_CELL_WIDTH  = gmdd_pkg::DEF_MAX_CELL_WIDTH,
   parameter int MAX_CELL_HEIGHT = gmdd_pkg::DEF_MAX_CELL_HEIGHT,
   parameter int MAX_BOLD_RADIUS = gmdd_pkg::DEF_MAX_BOLD_RADIUS
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request stream
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [gmdd_pkg::REQ_TDATA_W-1:0]     req_tdata,  // blue, green, red, cell_x, cell_y
   input  wire  [gmdd_pkg::REQ_TUSER_W-1:0]     req_tuser,  // func, first_pixel
   // response stream
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [gmdd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // mask_value
   // register write channel
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [gmdd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [gmdd_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic [gmdd_pkg::CFG_SIZE_W-1:0] cell_width_ff;
   logic [gmdd_pkg::CFG_SIZE_W-1:0] cell_height_ff;
   logic [gmdd_pkg::CFG_RAD_W-1:0]  bold_radius_ff;

   gmdd_pkg::cfg_type  cfg;
   gmdd_pkg::cmd_type  push_cmd, pop_cmd;
   logic               csr_write;
   logic               restart;
   logic               q_full, q_valid, q_push, q_pop;
   logic [gmdd_pkg::SIZE_W-1:0] w_ext, h_ext;
   logic [gmdd_pkg::RAD_W-1:0]  r_ext;

   // registers are to be written by the user only while the block is idle; the block does not enforce it
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   // any size change restarts the raster
   assign restart   = csr_write && (csr_index == gmdd_pkg::REG_CELL_WIDTH
                                    || csr_index == gmdd_pkg::REG_CELL_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff  <= gmdd_pkg::RESET_CELL_WIDTH;
         cell_height_ff <= gmdd_pkg::RESET_CELL_HEIGHT;
         bold_radius_ff <= gmdd_pkg::RESET_BOLD_RADIUS;
      end else if (csr_write) begin
         unique case (csr_index)
            gmdd_pkg::REG_CELL_WIDTH:  cell_width_ff  <= csr_data;
            gmdd_pkg::REG_CELL_HEIGHT: cell_height_ff <= csr_data;
            gmdd_pkg::REG_BOLD_RADIUS: bold_radius_ff <= csr_data[gmdd_pkg::CFG_RAD_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // clamp sizes to 1..max and radius to max
   assign w_ext = gmdd_pkg::SIZE_W'(cell_width_ff);
   assign h_ext = gmdd_pkg::SIZE_W'(cell_height_ff);
   assign r_ext = gmdd_pkg::RAD_W'(bold_radius_ff);

   always_comb begin
      if (w_ext == '0) begin
         cfg.eff_w = gmdd_pkg::SIZE_W'(1);
      end else if (w_ext > gmdd_pkg::SIZE_W'(MAX_CELL_WIDTH)) begin
         cfg.eff_w = gmdd_pkg::SIZE_W'(MAX_CELL_WIDTH);
      end else begin
         cfg.eff_w = w_ext;
      end
      if (h_ext == '0) begin
         cfg.eff_h = gmdd_pkg::SIZE_W'(1);
      end else if (h_ext > gmdd_pkg::SIZE_W'(MAX_CELL_HEIGHT)) begin
         cfg.eff_h = gmdd_pkg::SIZE_W'(MAX_CELL_HEIGHT);
      end else begin
         cfg.eff_h = h_ext;
      end
      cfg.rad = (r_ext > gmdd_pkg::RAD_W'(MAX_BOLD_RADIUS))
                ? gmdd_pkg::RAD_W'(MAX_BOLD_RADIUS) : r_ext;
   end

   // front: takes transfers, walks the raster, forms gray
   gmdd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .restart    (restart),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   // short queue so the front keeps taking transfers while the back scans
   gmdd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .pop_cmd   (pop_cmd),
      .full      (q_full),
      .not_empty (q_valid)
   );

   // back: accumulate 2x2 blocks, store levels, scan windows, hold the result
   gmdd_back #(
      .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
      .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
